>>> hdl/salsa20_stream_cipher_top_assert.svh
// assertion macros shared by the checker
`ifndef SALSA20_STREAM_CIPHER_TOP_ASSERT_SVH
`define SALSA20_STREAM_CIPHER_TOP_ASSERT_SVH

// same-cycle implication, sampled on the rising clock edge
`define S20_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define S20_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

>>> hdl/s20sc_pkg.sv
package s20sc_pkg;

	// input queue between front and back
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW = $clog2(FIFO_DEPTH + 1);

	// most beats in flight: full queue plus the output register
	localparam int PEND_MAX = FIFO_DEPTH + 1;
	localparam int PEND_W = $clog2(PEND_MAX + 1);

	// 10 double rounds, 4 quarter-round steps per round
	localparam int NUM_ROUND_STEPS = 80;
	localparam int STEP_W = $clog2(NUM_ROUND_STEPS);

	// state constants
	localparam logic [31:0] C_EXPA = 32'h61707865;
	localparam logic [31:0] C_ND3 = 32'h3320646e;
	localparam logic [31:0] C_ND1 = 32'h3120646e;
	localparam logic [31:0] C_2BY = 32'h79622d32;
	localparam logic [31:0] C_6BY = 32'h79622d36;
	localparam logic [31:0] C_TEK = 32'h6b206574;

	// register indexes
	localparam logic [2:0] CFG_KEY_MODE = 3'd0;
	localparam logic [2:0] CFG_KEY_0_7 = 3'd1;
	localparam logic [2:0] CFG_KEY_8_15 = 3'd2;
	localparam logic [2:0] CFG_KEY_16_23 = 3'd3;
	localparam logic [2:0] CFG_KEY_24_31 = 3'd4;
	localparam logic [2:0] CFG_NONCE = 3'd5;

	typedef logic [15:0][31:0] word_blk_t;

	typedef struct packed {
		logic [7:0] data;
		logic first;
	} item_t;

	typedef struct packed {
		logic start;
		logic wide;
		logic [3:0][63:0] key;
		logic [63:0] nonce;
		logic [63:0] counter;
	} gen_req_t;

	typedef struct packed {
		logic done;
	} gen_stat_t;

	// word indexes {a,b,c,d} of one quarter round; row selects row round
	function automatic logic [15:0] qr_lane(input logic row, input logic [1:0] lane);
		logic [3:0] a;
		logic [3:0] b;
		logic [3:0] c;
		logic [3:0] d;
		a = {lane, lane};
		if (row) begin
			b = {lane, lane + 2'd1};
			c = {lane, lane + 2'd2};
			d = {lane, lane + 2'd3};
		end else begin
			b = a + 4'd4;
			c = a + 4'd8;
			d = a + 4'd12;
		end
		return {a, b, c, d};
	endfunction

	// rotate left by the amount of the quarter-round step
	function automatic logic [31:0] step_rotl(input logic [31:0] v, input logic [1:0] phase);
		logic [31:0] r;
		unique case (phase)
			2'd0: r = {v[24:0], v[31:25]};
			2'd1: r = {v[22:0], v[31:23]};
			2'd2: r = {v[18:0], v[31:19]};
			default: r = {v[13:0], v[31:14]};
		endcase
		return r;
	endfunction

endpackage

>>> hdl/s20sc_fifo.sv
module s20sc_fifo import s20sc_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic push_valid,
	output logic push_ready,
	input item_t push_item,
	output logic head_valid,
	output item_t head_item,
	input logic pop
);

	item_t mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q;
	logic [FIFO_AW-1:0] rd_ptr_q;
	logic [FIFO_CW-1:0] count_q;
	logic do_push;
	logic do_pop;

	assign push_ready = count_q != FIFO_CW'(FIFO_DEPTH);
	assign head_valid = count_q != '0;
	assign head_item = mem_q[rd_ptr_q];
	assign do_push = push_valid && push_ready;
	assign do_pop = pop && head_valid;

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + FIFO_AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + FIFO_CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - FIFO_CW'(1);
			end
		end
	end

endmodule

>>> hdl/s20sc_core.sv
module s20sc_core import s20sc_pkg::*; (
	input logic clk,
	input logic arst_n,
	input gen_req_t req,
	output gen_stat_t stat,
	output word_blk_t words
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_ROUND = 2'd1;
	localparam logic [1:0] ST_FEED = 2'd2;

	logic [1:0] state_q;
	logic [STEP_W-1:0] step_q;
	logic done_q;
	word_blk_t x_q;
	word_blk_t init_q;
	word_blk_t init_w;
	word_blk_t x_nxt;
	logic [63:0] k2;
	logic [63:0] k3;

	assign stat.done = done_q;
	assign words = x_q;

	// initial state from key, nonce and block counter
	always_comb begin
		k2 = req.wide ? req.key[2] : req.key[0];
		k3 = req.wide ? req.key[3] : req.key[1];
		init_w[0] = C_EXPA;
		init_w[1] = req.key[0][31:0];
		init_w[2] = req.key[0][63:32];
		init_w[3] = req.key[1][31:0];
		init_w[4] = req.key[1][63:32];
		init_w[5] = req.wide ? C_ND3 : C_ND1;
		init_w[6] = req.nonce[31:0];
		init_w[7] = req.nonce[63:32];
		init_w[8] = req.counter[31:0];
		init_w[9] = req.counter[63:32];
		init_w[10] = req.wide ? C_2BY : C_6BY;
		init_w[11] = k2[31:0];
		init_w[12] = k2[63:32];
		init_w[13] = k3[31:0];
		init_w[14] = k3[63:32];
		init_w[15] = C_TEK;
	end

	// one add-rotate-xor step of all four quarter rounds
	always_comb begin
		logic [15:0] idx;
		logic [3:0] tgt;
		logic [3:0] s1;
		logic [3:0] s2;
		logic [31:0] sum;
		x_nxt = x_q;
		for (int lane = 0; lane < 4; lane++) begin
			idx = qr_lane(step_q[2], 2'(lane));
			unique case (step_q[1:0])
				2'd0: begin
					tgt = idx[11:8];
					s1 = idx[15:12];
					s2 = idx[3:0];
				end
				2'd1: begin
					tgt = idx[7:4];
					s1 = idx[11:8];
					s2 = idx[15:12];
				end
				2'd2: begin
					tgt = idx[3:0];
					s1 = idx[7:4];
					s2 = idx[11:8];
				end
				default: begin
					tgt = idx[15:12];
					s1 = idx[3:0];
					s2 = idx[7:4];
				end
			endcase
			sum = x_q[s1] + x_q[s2];
			x_nxt[tgt] = x_q[tgt] ^ step_rotl(sum, step_q[1:0]);
		end
	end

	// working state and feed-forward
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (req.start) begin
					x_q <= init_w;
					init_q <= init_w;
				end
			end
			ST_ROUND: begin
				x_q <= x_nxt;
			end
			ST_FEED: begin
				for (int i = 0; i < 16; i++) begin
					x_q[i] <= x_q[i] + init_q[i];
				end
			end
			default: begin
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (req.start) begin
						step_q <= '0;
						state_q <= ST_ROUND;
					end
				end
				ST_ROUND: begin
					step_q <= step_q + STEP_W'(1);
					if (step_q == STEP_W'(NUM_ROUND_STEPS - 1)) begin
						state_q <= ST_FEED;
					end
				end
				ST_FEED: begin
					done_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

>>> hdl/salsa20_stream_cipher_top.sv
// Salsa20/20 stream cipher, one byte per beat; encrypts and decrypts alike.
// Input channel in_valid/in_ready carries data_byte and first_byte; a set
// first_byte restarts the block counter and the byte position at zero.
// Output channel out_valid/out_ready carries result_byte, one per input beat,
// in order. Configuration: cfg_we writes cfg_data into register cfg_index
// (0 key mode, 1..4 key bytes, 5 nonce); write only while the block is idle.
// Input beats go into a four-entry queue; the back end takes them from there.
// A beat passes the queue and then the output register when the block is ready.
// At byte position zero a new 64-byte block is made by one shared round unit
// doing one add-rotate-xor step of all four quarter rounds per cycle: start,
// 80 round steps, feed-forward, the ready flag, then that byte's output beat.
// Throughput: one byte per cycle for the other 63 bytes of a block, while
// input beats are queued and the receiver does not stall.
// A stalled receiver holds the output register; the queue keeps taking beats
// until it is full, then in_ready drops.
// Reset clears queue, counter, position and config (key mode 256-bit, key and
// nonce zero); no clearing pass is needed.
module salsa20_stream_cipher_top import s20sc_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [7:0] data_byte,
	input logic first_byte,
	output logic out_valid,
	input logic out_ready,
	output logic [7:0] result_byte,
	input logic cfg_we,
	input logic [2:0] cfg_index,
	input logic [63:0] cfg_data
);

	logic key_mode_q;
	logic [3:0][63:0] key_q;
	logic [63:0] nonce_q;
	logic [63:0] ctr_q;
	logic [5:0] pos_q;
	logic ks_ready_q;
	logic gen_pend_q;
	logic out_valid_q;
	logic [7:0] result_q;

	item_t push_item;
	logic head_valid;
	item_t head_item;
	logic [5:0] eff_pos;
	logic need_block;
	logic gen_start;
	logic out_free;
	logic byte_fire;
	logic [63:0] gen_ctr;
	logic [31:0] ks_word;
	logic [7:0] ks_byte;
	gen_req_t req;
	gen_stat_t stat;
	word_blk_t words;

	assign push_item = '{data: data_byte, first: first_byte};

	// front: input queue
	s20sc_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push_valid(in_valid),
		.push_ready(in_ready),
		.push_item(push_item),
		.head_valid(head_valid),
		.head_item(head_item),
		.pop(byte_fire)
	);

	// classify the head beat
	assign eff_pos = head_item.first ? 6'd0 : pos_q;
	assign need_block = eff_pos == 6'd0;
	assign gen_ctr = head_item.first ? 64'd0 : ctr_q;
	assign gen_start = head_valid && need_block && !ks_ready_q && !gen_pend_q;
	assign out_free = !out_valid_q || out_ready;
	assign byte_fire = head_valid && (!need_block || ks_ready_q) && out_free;

	assign req = '{start: gen_start, wide: key_mode_q, key: key_q, nonce: nonce_q,
		counter: gen_ctr};

	// back: keystream block generator
	s20sc_core u_core (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.stat(stat),
		.words(words)
	);

	// keystream byte select
	assign ks_word = words[eff_pos[5:2]];
	assign ks_byte = ks_word[{eff_pos[1:0], 3'b000} +: 8];

	assign out_valid = out_valid_q;
	assign result_byte = result_q;

	// output data
	always_ff @(posedge clk) begin
		if (byte_fire) begin
			result_q <= head_item.data ^ ks_byte;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_mode_q <= 1'b1;
			key_q <= '0;
			nonce_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_KEY_MODE: key_mode_q <= cfg_data[0];
				CFG_KEY_0_7: key_q[0] <= cfg_data;
				CFG_KEY_8_15: key_q[1] <= cfg_data;
				CFG_KEY_16_23: key_q[2] <= cfg_data;
				CFG_KEY_24_31: key_q[3] <= cfg_data;
				CFG_NONCE: nonce_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// stream position, counter and handshake control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctr_q <= '0;
			pos_q <= '0;
			ks_ready_q <= 1'b0;
			gen_pend_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (gen_start) begin
				ctr_q <= gen_ctr + 64'd1;
				gen_pend_q <= 1'b1;
			end else if (stat.done) begin
				gen_pend_q <= 1'b0;
			end
			if (stat.done) begin
				ks_ready_q <= 1'b1;
			end else if (byte_fire) begin
				ks_ready_q <= 1'b0;
			end
			if (byte_fire) begin
				pos_q <= eff_pos + 6'd1;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

>>> hdl/s20sc_checker.sv
`include "salsa20_stream_cipher_top_assert.svh"

module s20sc_checker import s20sc_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic [7:0] result_byte
);

	logic [PEND_W-1:0] pend_q;
	logic in_acc;
	logic out_acc;

	assign in_acc = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	// beats accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (in_acc && !out_acc) begin
			pend_q <= pend_q + PEND_W'(1);
		end else if (out_acc && !in_acc) begin
			pend_q <= pend_q - PEND_W'(1);
		end
	end

	`S20_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(result_byte))
	`S20_ASSERT_IMPL(a_no_orphan, out_valid, pend_q != '0)
	`S20_ASSERT_IMPL(a_pend_bound, 1'b1, pend_q <= PEND_W'(PEND_MAX))
	`S20_ASSERT_IMPL(a_empty_ready, pend_q == '0, in_ready)

endmodule

bind salsa20_stream_cipher_top s20sc_checker u_s20sc_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_valid),
	.in_ready(in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.result_byte(result_byte)
);

>>> tb/tb_salsa20_stream_cipher_top.sv
`timescale 1ns / 1ps

module tb_salsa20_stream_cipher_top;
	import s20sc_pkg::*;

	// indexes past the last register; writes there must be ignored
	localparam logic [2:0] CFG_SPARE_6 = 3'd6;
	localparam logic [2:0] CFG_SPARE_7 = 3'd7;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 200;
	localparam int RANDOM_BYTES = 1350;

	typedef logic [31:0] salsa_words_t [16];

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [7:0] data_byte;
	logic first_byte;
	logic out_valid;
	logic out_ready;
	logic [7:0] result_byte;
	logic cfg_we;
	logic [2:0] cfg_index;
	logic [63:0] cfg_data;

	// cipher state as the block should hold it
	logic wide_key;
	logic [63:0] key_words [4];
	logic [63:0] nonce_reg;
	logic [63:0] block_ctr;
	salsa_words_t keystream;
	logic [5:0] byte_pos;

	logic [7:0] expected_bytes [$];

	bit gaps_on;
	int stall_left;
	int idle_cycles;
	int error_count;
	int bytes_sent;
	int bytes_checked;
	int messages_sent;
	int blocks_made;
	int reg_writes;

	salsa20_stream_cipher_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.data_byte(data_byte),
		.first_byte(first_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.result_byte(result_byte),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// clock
	always #1 clk = ~clk;

	function automatic logic [31:0] rotl32(input logic [31:0] v, input int s);
		return (v << s) | (v >> (32 - s));
	endfunction

	// one 64-byte salsa20/20 block from the current key, nonce and counter
	function automatic salsa_words_t keystream_block();
		salsa_words_t init;
		salsa_words_t x;
		logic [63:0] k2;
		logic [63:0] k3;
		logic [31:0] t;
		int a;
		int b;
		int c;
		int d;
		k2 = wide_key ? key_words[2] : key_words[0];
		k3 = wide_key ? key_words[3] : key_words[1];
		init[0] = C_EXPA;
		init[5] = wide_key ? C_ND3 : C_ND1;
		init[10] = wide_key ? C_2BY : C_6BY;
		init[15] = C_TEK;
		init[1] = key_words[0][31:0];
		init[2] = key_words[0][63:32];
		init[3] = key_words[1][31:0];
		init[4] = key_words[1][63:32];
		init[11] = k2[31:0];
		init[12] = k2[63:32];
		init[13] = k3[31:0];
		init[14] = k3[63:32];
		init[6] = nonce_reg[31:0];
		init[7] = nonce_reg[63:32];
		init[8] = block_ctr[31:0];
		init[9] = block_ctr[63:32];
		x = init;
		// even rounds work on columns, odd rounds on rows
		for (int r = 0; r < 20; r++) begin
			for (int l = 0; l < 4; l++) begin
				a = 5 * l;
				if (r % 2 == 0) begin
					b = (a + 4) % 16;
					c = (a + 8) % 16;
					d = (a + 12) % 16;
				end else begin
					b = 4 * l + (l + 1) % 4;
					c = 4 * l + (l + 2) % 4;
					d = 4 * l + (l + 3) % 4;
				end
				t = x[a] + x[d];
				x[b] = x[b] ^ rotl32(t, 7);
				t = x[b] + x[a];
				x[c] = x[c] ^ rotl32(t, 9);
				t = x[c] + x[b];
				x[d] = x[d] ^ rotl32(t, 13);
				t = x[d] + x[c];
				x[a] = x[a] ^ rotl32(t, 18);
			end
		end
		// feed-forward
		for (int i = 0; i < 16; i++)
			x[i] = x[i] + init[i];
		return x;
	endfunction

	// advance the cipher state by one byte and return the expected output byte
	function automatic logic [7:0] cipher_byte(input logic [7:0] value, input logic restart);
		logic [31:0] w;
		logic [7:0] out;
		if (restart) begin
			block_ctr = '0;
			byte_pos = '0;
		end
		if (byte_pos == 6'd0) begin
			keystream = keystream_block();
			block_ctr = block_ctr + 64'd1;
			blocks_made++;
		end
		w = keystream[byte_pos[5:2]];
		out = value ^ 8'(w >> (8 * byte_pos[1:0]));
		byte_pos = byte_pos + 6'd1;
		return out;
	endfunction

	// mostly short gaps, a few long ones
	function automatic int gap_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [63:0] config_value();
		int r;
		r = $urandom_range(0, 7);
		if (r == 0)
			return '0;
		if (r == 1)
			return '1;
		return {$urandom(), $urandom()};
	endfunction

	task automatic report_error(input string msg);
		error_count++;
		if (error_count <= 10)
			$display("error: %s", msg);
	endtask

	// send one input beat and record its expected output
	task automatic send_byte(input logic [7:0] value, input logic restart);
		int gap;
		gap = gaps_on ? gap_length() : 0;
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= value;
		first_byte <= restart;
		do @(posedge clk); while (!in_ready);
		expected_bytes = {expected_bytes, cipher_byte(value, restart)};
		bytes_sent++;
	endtask

	// hold off the sender until every expected beat has come out
	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_bytes.size() != 0)
			@(negedge clk);
	endtask

	// register write, only called while the block is idle
	task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		reg_writes++;
		case (idx)
			CFG_KEY_MODE: wide_key = value[0];
			CFG_KEY_0_7: key_words[0] = value;
			CFG_KEY_8_15: key_words[1] = value;
			CFG_KEY_16_23: key_words[2] = value;
			CFG_KEY_24_31: key_words[3] = value;
			CFG_NONCE: nonce_reg = value;
			default: ;
		endcase
	endtask

	// stream after reset with no first mark, default 256-bit zero key
	task automatic test_reset_defaults();
		send_byte(8'h00, 1'b0);
		send_byte(8'hff, 1'b0);
		messages_sent++;
	endtask

	// data extremes and a restart in the middle of a message
	task automatic test_field_extremes();
		send_byte(8'h00, 1'b1);
		send_byte(8'hff, 1'b0);
		send_byte(8'h5a, 1'b1);
		send_byte(8'ha5, 1'b0);
		messages_sent += 2;
	endtask

	// 128-bit and 256-bit keys with all-ones and all-zeros material
	task automatic test_key_modes();
		wait_drained();
		write_reg(CFG_KEY_MODE, 64'd0);
		write_reg(CFG_KEY_0_7, '1);
		write_reg(CFG_KEY_8_15, '1);
		write_reg(CFG_KEY_16_23, 64'h0123_4567_89ab_cdef);
		write_reg(CFG_KEY_24_31, 64'hfedc_ba98_7654_3210);
		write_reg(CFG_NONCE, '1);
		for (int i = 0; i < 4; i++)
			send_byte(8'($urandom_range(0, 255)), i == 0);
		wait_drained();
		write_reg(CFG_KEY_MODE, 64'd1);
		for (int i = 0; i < 4; i++)
			send_byte(8'($urandom_range(0, 255)), i == 0);
		wait_drained();
		// only bit 0 of the mode register counts
		write_reg(CFG_KEY_MODE, 64'hffff_ffff_ffff_fffe);
		write_reg(CFG_KEY_0_7, '0);
		write_reg(CFG_NONCE, '0);
		send_byte(8'hff, 1'b1);
		send_byte(8'h00, 1'b0);
		wait_drained();
		write_reg(CFG_KEY_MODE, 64'd1);
		messages_sent += 3;
	endtask

	// new nonce mid-block: the current keystream block stays in use
	task automatic test_config_mid_block();
		send_byte(8'h11, 1'b1);
		send_byte(8'h22, 1'b0);
		wait_drained();
		write_reg(CFG_NONCE, 64'h8000_0000_0000_0001);
		send_byte(8'h33, 1'b0);
		send_byte(8'h44, 1'b0);
		messages_sent++;
	endtask

	// writes to indexes past the register file change nothing
	task automatic test_unknown_index();
		wait_drained();
		write_reg(CFG_SPARE_6, '1);
		write_reg(CFG_SPARE_7, 64'hdead_beef_cafe_f00d);
		send_byte(8'h80, 1'b1);
		send_byte(8'h01, 1'b0);
		messages_sent++;
	endtask

	// random messages, mostly well formed, with reconfiguration in between
	task automatic test_random_messages(input int n_bytes);
		int len;
		bit carry_on;
		logic [2:0] idx;
		while (bytes_sent < n_bytes) begin
			// drain and reconfigure now and then
			if ($urandom_range(0, 3) == 0) begin
				wait_drained();
				for (int n = $urandom_range(1, 4); n > 0; n--) begin
					idx = 3'($urandom_range(0, 7));
					write_reg(idx, config_value());
				end
			end
			gaps_on = ($urandom_range(0, 5) != 0);
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(65, 260) :
				$urandom_range(1, 80);
			// keep the total near the planned byte count
			if (len > n_bytes - bytes_sent)
				len = n_bytes - bytes_sent;
			carry_on = ($urandom_range(0, 7) == 0);
			for (int i = 0; i < len; i++)
				send_byte(8'($urandom_range(0, 255)),
					(i == 0 && !carry_on) || ($urandom_range(0, 99) == 0));
			messages_sent++;
		end
		gaps_on = 1'b1;
	endtask

	// receiver stalls
	always @(negedge clk) begin
		if (gaps_on && stall_left == 0 && $urandom_range(0, 99) < 25)
			stall_left = gap_length();
		if (gaps_on && stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left--;
		end else
			out_ready <= 1'b1;
	end

	// compare each output beat with the oldest expected byte
	always @(posedge clk) begin
		logic [7:0] want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_bytes.size() == 0) begin
				report_error($sformatf("unexpected output byte %02h", result_byte));
			end else begin
				want = expected_bytes.pop_front();
				bytes_checked++;
				if (result_byte !== want)
					report_error($sformatf("output byte %0d: expected %02h, got %02h",
						bytes_checked, want, result_byte));
			end
		end
	end

	// watchdog on cycles without any accepted beat
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("timeout: no beat accepted for %0d cycles", WATCHDOG_LIMIT);
			$display("CHECK FAILED");
			$finish;
		end else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		data_byte = '0;
		first_byte = 1'b0;
		out_ready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_KEY_MODE;
		cfg_data = '0;
		gaps_on = 1'b1;
		stall_left = 0;
		idle_cycles = 0;
		error_count = 0;
		bytes_sent = 0;
		bytes_checked = 0;
		messages_sent = 0;
		blocks_made = 0;
		reg_writes = 0;
		wide_key = 1'b1;
		for (int i = 0; i < 4; i++)
			key_words[i] = '0;
		nonce_reg = '0;
		block_ctr = '0;
		byte_pos = '0;
		for (int i = 0; i < 16; i++)
			keystream[i] = '0;

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_defaults();
		test_field_extremes();
		test_key_modes();
		test_config_mid_block();
		test_unknown_index();
		test_random_messages(RANDOM_BYTES);

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_bytes.size() != 0)
			report_error($sformatf("%0d expected bytes never came out",
				expected_bytes.size()));

		$display("covered %0d bytes in %0d messages, %0d keystream blocks, %0d register writes",
			bytes_sent, messages_sent, blocks_made, reg_writes);
		$display("%0d bytes checked, %0d errors", bytes_checked, error_count);
		if (error_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
